[rtl/core/dpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline priority queue package
// Shared widths, opcodes, status codes, entry and result types, and the
// day arithmetic used by the queue sequencer.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int unsigned ACT_W    = 3;
  localparam int unsigned REL_W    = 16;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned DAY_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LEFT_W   = 16;
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 56;

  // Operation codes carried with each input item.
  localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;

  // Status codes returned with each result item.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // One stored queue entry.
  typedef struct packed {
    logic [DAY_W-1:0]  due;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ttype;
  } entry_t;

  // One finished result, as handed to the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ttype;
    logic [LEFT_W-1:0] left;
  } result_t;

  // Absolute due day, saturating at the top of the day range.
  function automatic logic [DAY_W-1:0] due_sum(logic [DAY_W-1:0] today,
                                               logic [REL_W-1:0] rel);
    logic [DAY_W:0] sum;
    sum = {1'b0, today} + {{(DAY_W + 1 - REL_W){1'b0}}, rel};
    if (sum[DAY_W]) begin
      due_sum = '1;
    end else begin
      due_sum = sum[DAY_W-1:0];
    end
  endfunction

  // Days remaining until due, floored at zero and clamped to the field.
  function automatic logic [LEFT_W-1:0] days_left(logic [DAY_W-1:0] due,
                                                  logic [DAY_W-1:0] today);
    logic [DAY_W-1:0] diff;
    diff = (due > today) ? (due - today) : '0;
    if (diff[DAY_W-1:LEFT_W] != '0) begin
      days_left = '1;
    end else begin
      days_left = diff[LEFT_W-1:0];
    end
  endfunction

endpackage

[rtl/core/dpq_entry_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue entry memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dpq_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  dpq_pkg::entry_t wr_data_i,
  input  logic [AW-1:0]   rd_addr_i,
  output dpq_pkg::entry_t rd_data_o
);
  import dpq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered output.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/dpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue sequencer
// Walks the sorted entry memory one entry per cycle to insert, search,
// pop and remove, and keeps the entry count and the current day.
// ----------------------------------------------------------------------------
module dpq_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dpq_pkg::ACT_W-1:0]     in_action_i,
  input  logic [dpq_pkg::REL_W-1:0]     in_rel_i,
  input  logic [dpq_pkg::ID_W-1:0]      in_id_i,
  input  logic [dpq_pkg::TYPE_W-1:0]    in_type_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output dpq_pkg::result_t              res_o
);
  import dpq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_WALK,
    S_INS_PUT,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [ACT_W-1:0]   act_q, act_d;
  logic [REL_W-1:0]   rel_q, rel_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [TYPE_W-1:0]  type_q, type_d;
  logic [DAY_W-1:0]   due_q, due_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic [DAY_W-1:0]   today_q, today_d;
  logic [STAT_W-1:0]  res_status_q, res_status_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;
  logic [TYPE_W-1:0]  res_type_q, res_type_d;
  logic [DAY_W-1:0]   res_due_q, res_due_d;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;
  logic [AW-1:0]      rd_addr;
  entry_t             rd_data;

  logic [CW-1:0]      idx_inc;
  logic [CW:0]        idx_inc2;
  logic [CW-1:0]      idx_dec;
  logic [CW-1:0]      count_dec;
  logic               hit;

  assign idx_inc   = idx_q + CW'(1);
  assign idx_inc2  = {1'b0, idx_q} + (CW + 1)'(2);
  assign idx_dec   = idx_q - CW'(1);
  assign count_dec = count_q - CW'(1);

  dpq_entry_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Match test for the entry whose read data arrives this cycle.
  always_comb begin
    unique case (act_q)
      ACT_FIND:   hit = (rd_data.ttype == type_q);
      ACT_REMOVE: hit = (rd_data.id == id_q);
      default:    hit = 1'b1;
    endcase
  end

  // Next-state logic. The walk never writes and reads the same entry in one
  // cycle, and each item starts only after the previous one has written back,
  // so the memory needs no forwarding.
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    rel_d        = rel_q;
    id_d         = id_q;
    type_d       = type_q;
    due_d        = due_q;
    idx_d        = idx_q;
    count_d      = count_q;
    today_d      = today_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_type_d   = res_type_q;
    res_due_d    = res_due_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[AW-1:0];
    wr_data      = rd_data;
    rd_addr      = idx_inc[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = in_action_i;
          rel_d   = in_rel_i;
          id_d    = in_id_i;
          type_d  = in_type_i;
          state_d = S_START;
        end
      end

      S_START: begin
        res_id_d   = '0;
        res_type_d = '0;
        res_due_d  = '0;
        unique case (act_q)
          ACT_ENQ: begin
            due_d = due_sum(today_q, rel_q);
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = STAT_FULL;
              state_d      = S_RESP;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_PUT;
            end else begin
              idx_d   = count_dec;
              rd_addr = count_dec[AW-1:0];
              state_d = S_INS_WALK;
            end
          end
          ACT_DEQ, ACT_PEEK, ACT_FIND, ACT_REMOVE: begin
            if (count_q == '0) begin
              res_status_d = STAT_MISS;
              state_d      = S_RESP;
            end else begin
              idx_d   = '0;
              rd_addr = '0;
              state_d = S_SCAN;
            end
          end
          default: begin
            res_status_d = STAT_MISS;
            state_d      = S_RESP;
          end
        endcase
      end

      // Move later entries up by one, from the tail toward the front.
      S_INS_WALK: begin
        rd_addr = idx_dec[AW-1:0];
        if (rd_data.due > due_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_inc[AW-1:0];
          if (idx_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            idx_d = idx_dec;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        wr_en        = 1'b1;
        wr_data      = '{due: due_q, id: id_q, ttype: type_q};
        count_d      = count_q + CW'(1);
        res_status_d = STAT_OK;
        res_id_d     = id_q;
        res_type_d   = type_q;
        res_due_d    = due_q;
        state_d      = S_RESP;
      end

      // Search from the front; the next entry is read ahead.
      S_SCAN: begin
        if (hit) begin
          res_status_d = STAT_OK;
          res_id_d     = rd_data.id;
          res_type_d   = rd_data.ttype;
          res_due_d    = rd_data.due;
          if (act_q == ACT_DEQ) begin
            today_d = rd_data.due;
          end
          if (act_q == ACT_DEQ || act_q == ACT_REMOVE) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_RESP;
          end
        end else if (idx_inc < count_q) begin
          idx_d = idx_inc;
        end else begin
          res_status_d = STAT_MISS;
          state_d      = S_RESP;
        end
      end

      // Close the gap left by the popped or removed entry.
      S_SHIFT: begin
        rd_addr = idx_inc2[AW-1:0];
        if (idx_inc < count_q) begin
          wr_en = 1'b1;
          idx_d = idx_inc;
        end else begin
          count_d = count_dec;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      today_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      today_q <= today_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    rel_q        <= rel_d;
    id_q         <= id_d;
    type_q       <= type_d;
    due_q        <= due_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_type_q   <= res_type_d;
    res_due_q    <= res_due_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  // A popped task leaves today equal to its due day, so its days left is zero.
  assign res_o = '{status: res_status_q,
                   id:     res_id_q,
                   ttype:  res_type_q,
                   left:   days_left(res_due_q, today_q)};

  // The entry count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The entry count moves by at most one per item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("entry count jumped");

  // Due days are never earlier than today, so today never goes back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    today_q >= $past(today_q))
    else $error("current day went backward");

  // An insert walk only runs when there is room for one more entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WALK) |-> (count_q < CW'(CAPACITY)))
    else $error("insert walk on a full queue");

endmodule

[rtl/core/deadline_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline priority queue unit
// Bounded task queue kept in order of absolute due day, with enqueue,
// dequeue, peek, find-by-type and remove-by-id operations.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY tasks in one single-port-write, single-port-
// read entry memory, sorted by due day, and handles one item at a time. Each
// item gives exactly one result item. An item goes through setup and a
// result state, plus a walk over the memory at one entry per cycle: an
// enqueue moves every entry due later than the new task (up to CAPACITY-1),
// a search reads from the front up to the match or the last entry, and a
// dequeue or remove then moves every entry behind the match forward by one.
// The result waits in an output register while the next item is worked on;
// a second result is held in the sequencer, and the queue stays busy, until
// the first one is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module deadline_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // days_till_due[15:0], task_id[47:16], task_type[50:48], zero fill above
  input  logic [dpq_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // action[2:0]
  input  logic [dpq_pkg::ACT_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_id[31:0], out_type[34:32], days_left[50:35], zero fill above
  output logic [dpq_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [dpq_pkg::STAT_W-1:0]     m_axis_tuser
);
  import dpq_pkg::*;

  localparam int unsigned M_FILL = M_DATA_W - ID_W - TYPE_W - LEFT_W;

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  logic                  m_valid_q;
  logic [M_DATA_W-1:0]   m_data_q;
  logic [STAT_W-1:0]     m_user_q;

  dpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_rel_i    (s_axis_tdata[REL_W-1:0]),
    .in_id_i     (s_axis_tdata[REL_W+ID_W-1:REL_W]),
    .in_type_i   (s_axis_tdata[REL_W+ID_W+TYPE_W-1:REL_W+ID_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {{M_FILL{1'b0}}, res.left, res.ttype, res.id};
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // A result waiting at the output is not replaced before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser)))
    else $error("output item changed while stalled");

  // Exactly one result per item: no new item is taken while one is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // Fill bits of a result are always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_DATA_W-1:M_DATA_W-M_FILL] == '0))
    else $error("result fill bits not zero");

endmodule

[tb/sv/deadline_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline priority queue unit testbench
// Drives enqueue, dequeue, peek, find and remove items into the queue and
// checks every result item against a cycle-free model of the sorted task
// store. The run has a few directed checks, segments of random traffic with
// idle gaps on both sides, and a run of the current day forward in the
// largest steps an enqueue allows.
// ----------------------------------------------------------------------------
module deadline_priority_queue_unit_tb;

  import dpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;

  // Operation codes that the queue does not know.
  localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

  // Traffic mixes for the random segments.
  localparam int unsigned MIX_FILL  = 0;
  localparam int unsigned MIX_DRAIN = 1;
  localparam int unsigned MIX_EVEN  = 2;

  // Relative due days for the directed fill, with ties and both extremes.
  localparam logic [16*REL_W-1:0] FILL_RELS = {
    16'd10,   16'd3,    16'h7FFF, 16'h8000, 16'd0, 16'd100, 16'd65534, 16'd1,
    16'd10,   16'h5555, 16'hAAAA, 16'd5,    16'd10, 16'd65535, 16'd0,  16'd10
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // days_till_due[15:0], task_id[47:16], task_type[50:48], zero fill above
  logic [S_DATA_W-1:0] s_axis_tdata;
  // action[2:0]
  logic [ACT_W-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // out_id[31:0], out_type[34:32], days_left[50:35], zero fill above
  logic [M_DATA_W-1:0] m_axis_tdata;
  // status[1:0]
  logic [STAT_W-1:0]   m_axis_tuser;

  // Model of the task store, sorted by due day from index 0.
  logic [DAY_W-1:0]  q_due  [QUEUE_DEPTH];
  logic [ID_W-1:0]   q_id   [QUEUE_DEPTH];
  logic [TYPE_W-1:0] q_type [QUEUE_DEPTH];
  int unsigned       q_count = 0;
  logic [DAY_W-1:0]  today_r = '0;

  // Results still owed by the queue, oldest first.
  result_t owed_results [$];

  int unsigned failures = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  deadline_priority_queue_unit #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Days from today to a due day, floored at zero and clamped to the field.
  function automatic logic [LEFT_W-1:0] days_to_go(input logic [DAY_W-1:0] due_day);
    logic [DAY_W-1:0] span;
    span = (due_day > today_r) ? due_day - today_r : '0;
    return (span > 32'h0000_FFFF) ? '1 : span[LEFT_W-1:0];
  endfunction

  // Successful result for a given task.
  function automatic result_t task_result(input logic [ID_W-1:0] id,
                                          input logic [TYPE_W-1:0] ttype,
                                          input logic [DAY_W-1:0] due_day);
    result_t res;
    res.status = STAT_OK;
    res.id     = id;
    res.ttype  = ttype;
    res.left   = days_to_go(due_day);
    return res;
  endfunction

  // Close the hole left by the entry at pos.
  function automatic void drop_entry(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_count; i++) begin
      q_due[i]  = q_due[i+1];
      q_id[i]   = q_id[i+1];
      q_type[i] = q_type[i+1];
    end
    q_count--;
  endfunction

  // Apply one item to the model and return the result it gives.
  function automatic result_t queue_apply(input logic [ACT_W-1:0] action,
                                          input logic [REL_W-1:0] rel,
                                          input logic [ID_W-1:0] id,
                                          input logic [TYPE_W-1:0] ttype);
    result_t          res;
    logic [DAY_W:0]   sum;
    logic [DAY_W-1:0] due_day;
    int unsigned      pos;
    res = '0;
    res.status = STAT_MISS;
    case (action)
      ACT_ENQ: begin
        if (q_count >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          sum = {1'b0, today_r} + {{(DAY_W + 1 - REL_W){1'b0}}, rel};
          due_day = sum[DAY_W] ? '1 : sum[DAY_W-1:0];
          // New task goes behind every entry due the same day or earlier.
          pos = 0;
          while (pos < q_count && q_due[pos] <= due_day) pos++;
          for (int unsigned i = q_count; i > pos; i--) begin
            q_due[i]  = q_due[i-1];
            q_id[i]   = q_id[i-1];
            q_type[i] = q_type[i-1];
          end
          q_due[pos]  = due_day;
          q_id[pos]   = id;
          q_type[pos] = ttype;
          q_count++;
          res = task_result(id, ttype, due_day);
        end
      end
      ACT_DEQ: begin
        if (q_count != 0) begin
          today_r = q_due[0];
          res = task_result(q_id[0], q_type[0], today_r);
          drop_entry(0);
        end
      end
      ACT_PEEK: begin
        if (q_count != 0) res = task_result(q_id[0], q_type[0], q_due[0]);
      end
      ACT_FIND: begin
        pos = q_count;
        for (int unsigned i = 0; i < q_count; i++) begin
          if (pos == q_count && q_type[i] == ttype) pos = i;
        end
        if (pos < q_count) res = task_result(q_id[pos], q_type[pos], q_due[pos]);
      end
      ACT_REMOVE: begin
        pos = q_count;
        for (int unsigned i = 0; i < q_count; i++) begin
          if (pos == q_count && q_id[i] == id) pos = i;
        end
        if (pos < q_count) begin
          res = task_result(q_id[pos], q_type[pos], q_due[pos]);
          drop_entry(pos);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offer one item, wait for it to be taken, then record what it should give.
  task automatic send_item(input logic [ACT_W-1:0] action, input logic [REL_W-1:0] rel,
                           input logic [ID_W-1:0] id, input logic [TYPE_W-1:0] ttype);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = action;
    s_axis_tdata  = '0;
    s_axis_tdata[0 +: REL_W]              = rel;
    s_axis_tdata[REL_W +: ID_W]           = id;
    s_axis_tdata[REL_W + ID_W +: TYPE_W]  = ttype;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    owed_results.push_back(queue_apply(action, rel, id, ttype));
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_results_done();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Relative days: many small values to make ties, some extremes, some anywhere.
  function automatic logic [REL_W-1:0] rand_rel();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return REL_W'($urandom_range(0, 3));
    if (roll < 60) return REL_W'($urandom_range(0, 40));
    if (roll < 75) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return REL_W'($urandom_range(0, 65535));
  endfunction

  // Identifiers: a small pool so that duplicates occur, the extremes, or anything.
  function automatic logic [ID_W-1:0] rand_id();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 7);
    if (roll < 50) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return $urandom();
  endfunction

  // One random item under the given traffic mix.
  task automatic random_item(input int unsigned mix);
    int unsigned       roll, enq_pct, deq_pct;
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   id;
    enq_pct = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 15 : 35;
    deq_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 45 : 25;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct)                     action = ACT_ENQ;
    else if (roll < enq_pct + deq_pct)      action = ACT_DEQ;
    else if (roll < enq_pct + deq_pct + 8)  action = ACT_PEEK;
    else if (roll < enq_pct + deq_pct + 20) action = ACT_FIND;
    else if (roll < 97)                     action = ACT_REMOVE;
    else action = ACT_W'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
    id = rand_id();
    // Removals mostly name a task that is really stored.
    if (action == ACT_REMOVE && q_count != 0 && $urandom_range(0, 9) < 7) begin
      id = q_id[$urandom_range(0, q_count - 1)];
    end
    send_item(action, rand_rel(), id, TYPE_W'($urandom_range(0, 7)));
  endtask

  // Every operation on an empty queue, and an unknown code.
  task automatic test_empty_queue();
    send_item(ACT_DEQ, '0, '0, '0);
    send_item(ACT_PEEK, '1, '1, '1);
    send_item(ACT_FIND, '0, '0, '0);
    send_item(ACT_REMOVE, '0, '0, '0);
    send_item(ACT_BAD_HI, '1, '1, '1);
  endtask

  // Fill to capacity with ties and extreme fields, then one enqueue too many.
  task automatic test_fill_to_capacity();
    logic [ID_W-1:0] id;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      id = (i == 0) ? '0 : (i == 1) ? '1 : 32'hA5A5_0000 + (i % 12);
      send_item(ACT_ENQ, FILL_RELS[i*REL_W +: REL_W], id, TYPE_W'(i % 8));
    end
    send_item(ACT_ENQ, 16'd7, 32'h1234_5678, 3'd7);
  endtask

  // Lookups on the full queue; the removal hits the first of two equal ids.
  task automatic test_lookup_and_remove();
    send_item(ACT_PEEK, '0, '0, '0);
    send_item(ACT_FIND, '0, '0, 3'd7);
    send_item(ACT_REMOVE, '0, 32'hA5A5_0002, '0);
    send_item(ACT_REMOVE, '0, 32'hDEAD_BEEF, '0);
  endtask

  // Segments of random traffic, each with its own mix and idle pattern.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent, seg_len, mix;
    sent = 0;
    while (sent < n_items) begin
      seg_len = $urandom_range(40, 100);
      mix = $urandom_range(MIX_FILL, MIX_EVEN);
      case ($urandom_range(0, 3))
        0: begin
          src_gaps_on = 1'b0;
          sink_stalls_on = 1'b0;
        end
        1: begin
          src_gaps_on = 1'b1;
          sink_stalls_on = 1'b0;
        end
        2: begin
          src_gaps_on = 1'b0;
          sink_stalls_on = 1'b1;
        end
        default: begin
          src_gaps_on = 1'b1;
          sink_stalls_on = 1'b1;
        end
      endcase
      repeat (seg_len) random_item(mix);
      sent += seg_len;
      if ($urandom_range(0, 3) == 0) wait_results_done();
    end
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Move today forward in large steps, then work at the far end of the window.
  task automatic test_day_advance();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    while (q_count != 0) send_item(ACT_DEQ, '0, '0, '0);
    // Each pair moves today forward by the largest step an enqueue allows.
    repeat (32) begin
      send_item(ACT_ENQ, '1, $urandom(), TYPE_W'($urandom_range(0, 7)));
      send_item(ACT_DEQ, '0, '0, '0);
    end
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    // Two tasks tied at the latest due day, then lookups on them.
    send_item(ACT_ENQ, '1, 32'h0000_1111, 3'd1);
    send_item(ACT_ENQ, '1, 32'h0000_2222, 3'd2);
    send_item(ACT_PEEK, '0, '0, '0);
    send_item(ACT_FIND, '0, '0, 3'd2);
    send_item(ACT_DEQ, '0, '0, '0);
    send_item(ACT_DEQ, '0, '0, '0);
    // A task due at once beside one at the latest due day.
    send_item(ACT_ENQ, '0, 32'h0000_3333, 3'd3);
    send_item(ACT_ENQ, '1, 32'h0000_4444, 3'd4);
    send_item(ACT_REMOVE, '0, 32'h0000_4444, '0);
    repeat (120) random_item(MIX_EVEN);
  endtask

  // Result sink: runs of ready broken by stalls of random length.
  initial begin : result_sink
    int unsigned run_len, hold_len;
    m_axis_tready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      hold_len = sink_stalls_on ? pick_gap() : 0;
      repeat (hold_len) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
    end
  end

  // Compare each result taken with the oldest owed one.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $error("result with none owed: status %0d out_id %h", m_axis_tuser,
               m_axis_tdata[ID_W-1:0]);
        failures++;
      end else begin
        want = owed_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata[0 +: ID_W] !== want.id) begin
          $error("out_id: expected %h, got %h", want.id, m_axis_tdata[0 +: ID_W]);
          failures++;
        end
        if (m_axis_tdata[ID_W +: TYPE_W] !== want.ttype) begin
          $error("out_type: expected %0d, got %0d", want.ttype,
                 m_axis_tdata[ID_W +: TYPE_W]);
          failures++;
        end
        if (m_axis_tdata[ID_W + TYPE_W +: LEFT_W] !== want.left) begin
          $error("days_left: expected %0d, got %0d", want.left,
                 m_axis_tdata[ID_W + TYPE_W +: LEFT_W]);
          failures++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_fill_to_capacity();
    test_lookup_and_remove();
    wait_results_done();
    test_random_traffic(1150);
    test_day_advance();

    wait_results_done();
    repeat (40) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a queue that stops answering.
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
